// ===== rtl/signed_int_to_padded_decimal_ascii_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text converter
// Shared property forms, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_PADDED_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_PADDED_DECIMAL_ASCII_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SIDA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sida: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SIDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sida: next-cycle check failed");

`endif

// ===== rtl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Widths, character codes, register indexes and state type for the
// signed integer to padded decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam int ValueW    = 32;
  localparam int NumDigits = 10;
  localparam int DigitW    = 4;
  localparam int CharW     = 8;
  localparam int WidthW    = 7;
  localparam int CountW    = 4;
  localparam int ShiftCntW = $clog2(ValueW);

  localparam logic [WidthW-1:0]    MaxField   = 7'd64;
  localparam logic [ShiftCntW-1:0] LastShift  = ShiftCntW'(ValueW - 1);

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;
  localparam logic [CharW-1:0] FillReset  = 8'd32;

  // Configuration register indexes
  localparam logic CfgFieldWidth = 1'b0;
  localparam logic CfgFillChar   = 1'b1;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } sida_state_e;

endpackage

`default_nettype wire

// ===== rtl/sida_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// sida_bcd_conv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle,
// one step per magnitude bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_bcd_conv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [sida_pkg::ValueW-1:0]   mag_i,
  output logic                               done_o,
  output sida_pkg::digits_t                  digits_o
);
  import sida_pkg::*;

  localparam int BcdW = NumDigits * DigitW;

  digits_t              bcd_q, bcd_d;
  logic [ValueW-1:0]    bin_q, bin_d;
  logic [ShiftCntW-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [BcdW-1:0]      adj;

  // Add 3 to every digit of five or more, then shift the whole word left
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  // Sequence the shifts
  always_comb begin
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bcd_d = '0;
      bin_d = mag_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = digits_t'({adj[BcdW-2:0], bin_q[ValueW-1]});
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastShift) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_padded_decimal_ascii_top.sv =====
// First character: after 32 BCD shift steps of the shift-add-3 unit, the done
//   register, the sizing state and the output register.
// Throughput: one character per cycle while emitting, N characters per item,
//   N = max(saturated field width, sign + digits); a new item is taken in the
//   cycle that shows the last character.
// Reset: field width 0, fill character space, sequencer idle, no strobe.
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii_top
// Converts one signed value to padded decimal text, one character per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_padded_decimal_ascii_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_addr_i,
  input  wire logic [sida_pkg::CharW-1:0]   cfg_wdata_i,
  input  wire logic                         start_i,
  input  wire logic [sida_pkg::ValueW-1:0]  value_i,
  output logic                              busy_o,
  output logic                              valid_o,
  output logic [sida_pkg::CharW-1:0]        char_out_o,
  output logic                              last_o
);
  import sida_pkg::*;

  sida_state_e          state_q, state_d;
  logic [WidthW-1:0]    width_q;
  logic [CharW-1:0]     fill_q;
  logic                 neg_q, neg_d;
  logic [CountW-1:0]    dcount_q, dcount_d;
  logic [WidthW-1:0]    total_q, total_d;
  logic [WidthW-1:0]    k_q, k_d;
  logic                 valid_q, valid_d;
  logic                 last_q, last_d;
  logic [CharW-1:0]     char_q, char_d;

  logic                 accept;
  logic [ValueW-1:0]    mag;
  logic                 conv_done;
  digits_t              digits;
  logic [WidthW-1:0]    wsat;
  logic [WidthW-1:0]    body;
  logic [WidthW-1:0]    fill_lim;
  logic [WidthW-1:0]    rev_idx;
  logic [DigitW-1:0]    cur_digit;

  assign accept = start_i && (state_q == ST_IDLE);
  assign mag    = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;

  sida_bcd_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .mag_i    (mag),
    .done_o   (conv_done),
    .digits_o (digits)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
      fill_q  <= FillReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgFieldWidth: width_q <= cfg_wdata_i[WidthW-1:0];
        CfgFillChar:   fill_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturate the field width and size the text
  always_comb begin
    wsat     = (width_q > MaxField) ? MaxField : width_q;
    dcount_d = CountW'(1);
    for (int i = 1; i < NumDigits; i++) begin
      if (digits[i] != '0) dcount_d = CountW'(i + 1);
    end
    body    = WidthW'(dcount_d) + WidthW'(neg_q);
    total_d = (wsat > body) ? wsat : body;
  end

  // Pick the character for the current emit position
  assign fill_lim  = total_q - WidthW'(dcount_q);
  assign rev_idx   = total_q - WidthW'(1) - k_q;
  assign cur_digit = digits[rev_idx[CountW-1:0]];

  // Sequencer: next state and emitted character
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    k_d     = k_q;
    valid_d = 1'b0;
    last_d  = 1'b0;
    char_d  = char_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d   = value_i[ValueW-1];
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) state_d = ST_SIZE;
      end
      ST_SIZE: begin
        k_d     = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        valid_d = 1'b1;
        last_d  = (k_q == total_q - WidthW'(1));
        if (neg_q && (k_q == '0)) begin
          char_d = AsciiMinus;
        end else if (k_q < fill_lim) begin
          char_d = fill_q;
        end else begin
          char_d = AsciiZero + CharW'(cur_digit);
        end
        k_d = k_q + 1'b1;
        if (last_d) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
      k_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      k_q     <= k_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  // Hold size and output character
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (state_q == ST_SIZE) begin
      dcount_q <= dcount_d;
      total_q  <= total_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// ===== rtl/sida_checker.sv =====
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks on the converter's start, busy and character strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_padded_decimal_ascii_top_macros.svh"

module sida_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_i,
  input wire logic valid_i,
  input wire logic last_i
);

  // An accepted item makes the block busy and silent in the next cycle
  `SIDA_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)
  `SIDA_ASSERT_NEXT(a_accept_quiet, start_i && !busy_i, !valid_i)
  // A character shown while idle is always the final one of its text
  `SIDA_ASSERT_SAME(a_idle_char_last, valid_i && !busy_i, last_i)
  // The final flag never stands without a strobe
  `SIDA_ASSERT_SAME(a_last_valid, last_i, valid_i)

endmodule

bind signed_int_to_padded_decimal_ascii_top sida_checker u_sida_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .valid_i (valid_o),
  .last_i  (last_o)
);

`default_nettype wire

// ===== tb/sv/signed_int_to_padded_decimal_ascii_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal text checker
// Watches the register port, the item port and the character stream of the
// signed integer to padded decimal text converter. It keeps its own copy of
// the field width and fill character, works out the full text of every
// accepted item and compares each strobed character against it in order.
// ----------------------------------------------------------------------------

module signed_int_to_padded_decimal_ascii_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [sida_pkg::CharW-1:0]  cfg_wdata_i,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [sida_pkg::ValueW-1:0] value_i,
  input  logic                        valid_i,
  input  logic [sida_pkg::CharW-1:0]  char_i,
  input  logic                        last_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import sida_pkg::*;

  localparam int unsigned Radix = 10;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  logic [WidthW-1:0] field_width_q;
  logic [CharW-1:0]  fill_char_q;
  text_char_t        text_q[$];

  // Append the whole text of one value to the expected stream
  function automatic void queue_decimal_text(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digits [NumDigits];
    int unsigned       n_digits;
    int unsigned       sign_len;
    int unsigned       width;
    int unsigned       body;
    int unsigned       total;
    int unsigned       pad;
    text_char_t        tc;
    sign_len = value[ValueW-1];
    mag      = value[ValueW-1] ? (32'd0 - value) : value;
    width    = (field_width_q > MaxField) ? MaxField : field_width_q;
    n_digits = 0;
    // split into digits, least significant first
    do begin
      digits[n_digits] = DigitW'(mag % Radix);
      mag              = mag / Radix;
      n_digits++;
    end while (mag != 0 && n_digits < NumDigits);
    body  = n_digits + sign_len;
    total = (width > body) ? width : body;
    pad   = total - body;
    for (int unsigned k = 0; k < total; k++) begin
      if (sign_len != 0 && k == 0) begin
        tc.ch = AsciiMinus;
      end else if (k < sign_len + pad) begin
        tc.ch = fill_char_q;
      end else begin
        tc.ch = AsciiZero + CharW'(digits[n_digits - 1 - (k - sign_len - pad)]);
      end
      tc.last = (k == total - 1);
      text_q.push_back(tc);
    end
  endfunction

  // Track registers, predict on accept, compare each strobed character
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      field_width_q <= '0;
      fill_char_q   <= FillReset;
      fail_count_o  <= 0;
      pending_o     <= 0;
      text_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgFieldWidth) field_width_q <= cfg_wdata_i[WidthW-1:0];
        else if (cfg_addr_i == CfgFillChar) fill_char_q <= cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        queue_decimal_text(value_i);
      end
      if (valid_i === 1'b1) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected character: expected none got %0d last %0b",
                   $time, char_i, last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = text_q.pop_front();
          if (char_i !== want.ch || last_i !== want.last) begin
            $display("%0t: character mismatch: expected %0d last %0b got %0d last %0b",
                     $time, want.ch, want.last, char_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end else if (valid_i !== 1'b0) begin
        $display("%0t: strobe unknown: expected 0 or 1 got %b", $time, valid_i);
        fail_count_o <= fail_count_o + 1;
      end
      pending_o <= text_q.size();
    end
  end

endmodule

// ===== tb/sv/signed_int_to_padded_decimal_ascii_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal text converter testbench
// Drives directed and random signed values through the converter over a
// range of field widths and fill characters, with random gaps between items
// and drained pauses, while the checker compares every character strobed.
// ----------------------------------------------------------------------------

module signed_int_to_padded_decimal_ascii_top_test;
  import sida_pkg::*;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned RandomItems = 392;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_addr_i;
  logic [CharW-1:0]  cfg_wdata_i;
  logic              start_i;
  logic [ValueW-1:0] value_i;
  logic              busy_o;
  logic              valid_o;
  logic [CharW-1:0]  char_out_o;
  logic              last_o;
  int unsigned       fail_count;
  int unsigned       text_pending;
  int unsigned       idle_cycles = 0;

  signed_int_to_padded_decimal_ascii_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .valid_o     (valid_o),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

  signed_int_to_padded_decimal_ascii_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .value_i      (value_i),
    .valid_i      (valid_o),
    .char_i       (char_out_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (text_pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item after an optional settle and gap, hold until taken
  task automatic send_value(input logic [ValueW-1:0] v, input int unsigned gap,
                            input bit settle);
    if (settle || gap != 0) begin
      start_i <= 1'b0;
      if (settle) begin
        do @(posedge clk_i); while (busy_o);
      end
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and wait until every character has come out
  task automatic drain_text();
    start_i <= 1'b0;
    do @(posedge clk_i); while (text_pending != 0 || busy_o);
  endtask

  // Write both registers; the block must be idle
  task automatic set_format(input logic [CharW-1:0] width, input logic [CharW-1:0] fill);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgFieldWidth;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_addr_i  <= CfgFillChar;
    cfg_wdata_i <= fill;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Values biased towards digit-count boundaries and the extremes
  function automatic logic [ValueW-1:0] draw_value();
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] p;
    case ($urandom_range(0, 5))
      0: v = ValueW'($urandom_range(0, 40)) - 32'd20;
      1: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + ValueW'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      2: v = $urandom_range(0, 1) ? 32'h8000_0000 + ValueW'($urandom_range(0, 2))
                                  : 32'h7fff_ffff - ValueW'($urandom_range(0, 2));
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Field widths mostly small, sometimes wide or past saturation
  function automatic logic [CharW-1:0] draw_width();
    case ($urandom_range(0, 9))
      6, 7:    return CharW'($urandom_range(0, 64));
      8:       return CharW'($urandom_range(65, 255));
      9:       return CharW'($urandom_range(10, 12));
      default: return CharW'($urandom_range(0, 14));
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned run_len;
    bit          burst;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= CfgFieldWidth;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    value_i     <= '0;
    rst_ni      <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset format: no padding, space fill
    send_value(32'd0, 0, 0);
    send_value(32'd7, 0, 0);
    send_value(32'hffff_ffff, 1, 1);
    send_value(32'h7fff_ffff, 0, 0);
    send_value(32'h8000_0000, 2, 0);
    drain_text();

    // width one: zero stays a single digit
    set_format(8'd1, 8'd42);
    send_value(32'd0, 0, 0);
    send_value(32'd9, 0, 0);
    send_value(32'hffff_fff6, 0, 1);
    drain_text();

    // width exactly the longest text, zero fill
    set_format(8'd11, 8'd48);
    send_value(32'h8000_0000, 0, 0);
    send_value(32'd1_000_000_000, 0, 0);
    send_value(32'd0, 3, 0);
    send_value(32'hc465_3601, 0, 0);
    drain_text();

    // widest field, fill all ones
    set_format(8'd64, 8'hff);
    send_value(32'd123_456_789, 0, 0);
    send_value(32'hffff_ffff, 0, 0);
    drain_text();

    // saturated widths, fill zero, space and dot
    set_format(8'd127, 8'h00);
    send_value(32'd10, 0, 0);
    send_value(32'h8000_0001, 0, 0);
    drain_text();
    set_format(8'hff, 8'h20);
    send_value(32'd99, 5, 1);
    drain_text();
    set_format(8'd65, 8'h2e);
    send_value(32'h7fff_ffff, 0, 0);
    drain_text();

    // random phases, each under a fresh format
    sent = 0;
    while (sent < RandomItems) begin
      set_format(draw_width(), CharW'($urandom_range(0, 255)));
      run_len = $urandom_range(8, 40);
      if (run_len > RandomItems - sent) run_len = RandomItems - sent;
      burst   = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        if (!burst && $urandom_range(0, 24) == 0) drain_text();
        if (burst) send_value(draw_value(), 0, 0);
        else send_value(draw_value(), $urandom_range(0, 5), $urandom_range(0, 1));
        sent++;
      end
      drain_text();
    end

    // let any stray strobe show up, then report
    repeat (120) @(posedge clk_i);
    if (fail_count == 0 && text_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
